// ===== hw/rtl/p2s_pkg.sv =====
// p2s_pkg: shared types and constants of the premultiplied to straight alpha converter
`default_nettype none

package p2s_pkg;

  // packing of the incoming pixel word
  typedef enum logic [1:0] {
    FmtArgb = 2'd0,
    FmtAbgr = 2'd1,
    FmtXrgb = 2'd2,
    FmtXbgr = 2'd3
  } p2s_fmt_e;

  // quotient bits per colour, divider steps per register stage
  localparam int unsigned QuotBits      = 8;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumDivStages  = QuotBits / StepsPerStage;

  // colour lanes: 0 red, 1 green, 2 blue
  localparam int unsigned NumLanes = 3;
  localparam int unsigned LaneRed   = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneBlue  = 2;

  localparam logic [7:0] OpaqueAlpha = 8'hFF;
  localparam logic [7:0] MaxColor    = 8'hFF;

  // per lane divider state: partial remainder and numerator / quotient shifter
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] nq;
  } p2s_lane_t;

  // one pixel in flight
  typedef struct packed {
    p2s_lane_t [NumLanes-1:0] lane;
    logic [NumLanes-1:0]      sat;
    logic                     zero;
    logic [7:0]               alpha;
    logic                     last;
  } p2s_pix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/premultiplied_to_straight_rgba_unit.sv =====
// premultiplied_to_straight_rgba_unit: top level, pixel unpremultiply pipeline
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    pixel_word_i, last_in_i
//   out      output     out_valid_o / out_stall_i  red_o, green_o, blue_o,
//                                                  alpha_out_o, last_out_o
//   cfg      input      cfg_valid_i / cfg_ready_o  pixel_format_i
//
// one word per cycle while out_stall_i is low; registers in order: unpack, four divider stages
// of two quotient bits each, output register
// each stage holds its word while the next is full, so bubbles close up under stall
// async active-low reset clears stage valids and sets the format to ARGB
// cfg is always ready; the format applies to words entering after the write
`default_nettype none

module premultiplied_to_straight_rgba_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  pixel_format_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] pixel_word_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_out_o,
  output logic        last_out_o
);

  localparam int unsigned NumStg = p2s_pkg::NumDivStages;

  p2s_pkg::p2s_fmt_e  fmt_q;
  logic               stg_valid [NumStg+1];
  p2s_pkg::p2s_pix_t  stg_pix   [NumStg+1];
  logic               stg_ready [NumStg+2];
  logic               out_valid_q;
  logic [7:0]         res_d     [p2s_pkg::NumLanes];
  logic [7:0]         res_q     [p2s_pkg::NumLanes];
  logic [7:0]         alpha_q;
  logic               last_q;
  p2s_pkg::p2s_pix_t  fin_pix;

  // format register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= p2s_pkg::FmtArgb;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= p2s_pkg::p2s_fmt_e'(pixel_format_i);
    end
  end

  // unpack stage
  p2s_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fmt_i        (fmt_q),
    .valid_i      (in_valid_i),
    .pixel_word_i (pixel_word_i),
    .last_i       (last_in_i),
    .ready_o      (stg_ready[0]),
    .down_ready_i (stg_ready[1]),
    .valid_o      (stg_valid[0]),
    .pix_o        (stg_pix[0])
  );

  assign in_stall_o = !stg_ready[0];

  // divider stages
  for (genvar i = 0; i < NumStg; i++) begin : g_div
    p2s_div_stage u_div (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (stg_valid[i]),
      .pix_i        (stg_pix[i]),
      .ready_o      (stg_ready[i+1]),
      .down_ready_i (stg_ready[i+2]),
      .valid_o      (stg_valid[i+1]),
      .pix_o        (stg_pix[i+1])
    );
  end

  assign fin_pix = stg_pix[NumStg];

  // zero alpha and saturation select
  always_comb begin
    for (int k = 0; k < p2s_pkg::NumLanes; k++) begin
      if (fin_pix.zero) begin
        res_d[k] = 8'd0;
      end else if (fin_pix.sat[k]) begin
        res_d[k] = p2s_pkg::MaxColor;
      end else begin
        res_d[k] = fin_pix.lane[k].nq;
      end
    end
  end

  // output register
  assign stg_ready[NumStg+1] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_ready[NumStg+1]) begin
      out_valid_q <= stg_valid[NumStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_ready[NumStg+1] && stg_valid[NumStg]) begin
      res_q   <= res_d;
      alpha_q <= fin_pix.alpha;
      last_q  <= fin_pix.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = res_q[p2s_pkg::LaneRed];
  assign green_o     = res_q[p2s_pkg::LaneGreen];
  assign blue_o      = res_q[p2s_pkg::LaneBlue];
  assign alpha_out_o = alpha_q;
  assign last_out_o  = last_q;

`ifndef SYNTH
  // input only backs up when the output word is held
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  // zero alpha gives zero colour
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (alpha_out_o == 8'd0)) |->
      ((red_o == 8'd0) && (green_o == 8'd0) && (blue_o == 8'd0)))
    else $error("nonzero colour with zero alpha");

  // green lane divider remainder stays below the divisor on the last stage
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[NumStg] && !fin_pix.zero && !fin_pix.sat[p2s_pkg::LaneGreen]) |->
      (fin_pix.lane[p2s_pkg::LaneGreen].rem < fin_pix.alpha))
    else $error("divider remainder out of range");

  // opaque words give green no greater than full scale
  a_opaque_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (alpha_out_o == p2s_pkg::OpaqueAlpha)) |->
      (green_o <= p2s_pkg::MaxColor))
    else $error("opaque word out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/p2s_unpack.sv =====
// p2s_unpack: format decode and dividend setup, first pipeline stage
`default_nettype none

module p2s_unpack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2s_pkg::p2s_fmt_e   fmt_i,
  input  logic                valid_i,
  input  logic [31:0]         pixel_word_i,
  input  logic                last_i,
  output logic                ready_o,
  input  logic                down_ready_i,
  output logic                valid_o,
  output p2s_pkg::p2s_pix_t   pix_o
);

  logic               valid_q;
  p2s_pkg::p2s_pix_t  pix_q, pix_d;
  logic               carries_a, red_high;
  logic [7:0]         alpha;
  logic [7:0]         col   [p2s_pkg::NumLanes];
  logic [15:0]        num   [p2s_pkg::NumLanes];

  // format decode
  assign carries_a = (fmt_i == p2s_pkg::FmtArgb) || (fmt_i == p2s_pkg::FmtAbgr);
  assign red_high  = (fmt_i == p2s_pkg::FmtArgb) || (fmt_i == p2s_pkg::FmtXrgb);
  assign alpha     = carries_a ? pixel_word_i[31:24] : p2s_pkg::OpaqueAlpha;

  assign col[p2s_pkg::LaneRed]   = red_high ? pixel_word_i[23:16] : pixel_word_i[7:0];
  assign col[p2s_pkg::LaneGreen] = pixel_word_i[15:8];
  assign col[p2s_pkg::LaneBlue]  = red_high ? pixel_word_i[7:0] : pixel_word_i[23:16];

  // dividend c*255 + a/2, quotient saturates when c >= a
  always_comb begin
    pix_d       = '0;
    pix_d.alpha = alpha;
    pix_d.zero  = (alpha == 8'd0);
    pix_d.last  = last_i;
    for (int k = 0; k < p2s_pkg::NumLanes; k++) begin
      num[k] = {col[k], 8'h00} - {8'h00, col[k]} + {9'h000, alpha[7:1]};
      pix_d.lane[k].rem = num[k][15:8];
      pix_d.lane[k].nq  = num[k][7:0];
      pix_d.sat[k]      = (col[k] >= alpha);
    end
  end

  assign ready_o = !valid_q || down_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

// ===== hw/rtl/p2s_div_stage.sv =====
// p2s_div_stage: one register stage of the restoring divider, all colour lanes
`default_nettype none

module p2s_div_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  p2s_pkg::p2s_pix_t   pix_i,
  output logic                ready_o,
  input  logic                down_ready_i,
  output logic                valid_o,
  output p2s_pkg::p2s_pix_t   pix_o
);

  logic               valid_q;
  p2s_pkg::p2s_pix_t  pix_q, pix_d;

  // restoring division steps, one quotient bit each
  always_comb begin
    logic [8:0] t;
    logic [7:0] r;
    logic [7:0] nq;
    pix_d = pix_i;
    t     = '0;
    for (int k = 0; k < p2s_pkg::NumLanes; k++) begin
      r  = pix_i.lane[k].rem;
      nq = pix_i.lane[k].nq;
      for (int s = 0; s < p2s_pkg::StepsPerStage; s++) begin
        t = {r, nq[7]};
        if (t >= {1'b0, pix_i.alpha}) begin
          t  = t - {1'b0, pix_i.alpha};
          r  = t[7:0];
          nq = {nq[6:0], 1'b1};
        end else begin
          r  = t[7:0];
          nq = {nq[6:0], 1'b0};
        end
      end
      pix_d.lane[k].rem = r;
      pix_d.lane[k].nq  = nq;
    end
  end

  assign ready_o = !valid_q || down_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire
